// ----- design/periodic_interval_timer_unit_macros.svh -----
// Assertion macros for the periodic interval timer unit.
// Expects clk and arst_n in the scope that uses them; no other dependencies.
`ifndef PERIODIC_INTERVAL_TIMER_UNIT_MACROS_SVH
`define PERIODIC_INTERVAL_TIMER_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PITU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PITU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pitu_pkg.sv -----
// Shared types and constants for the periodic interval timer unit.
// No dependencies.
package pitu_pkg;

	localparam int unsigned DEF_INTERVAL_BITS = 20;
	localparam int unsigned DEF_WRAP_BITS     = 12;

	// request kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_STATUS = 2'd1;
	localparam logic [1:0] REG_VALUE  = 2'd2;
	localparam logic [1:0] REG_PEEK   = 2'd3;

	// mode word bits
	localparam int unsigned EN_BIT  = 24;
	localparam int unsigned IEN_BIT = 25;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  reg_index;
		logic [31:0] write_data;
	} req_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        access_error;
	} rsp_item_t;

endpackage

// ----- design/pitu_core.sv -----
// Timer state and single-pass item processing for the periodic interval timer unit.
// Depends on pitu_pkg.
module pitu_core #(
	parameter int unsigned INTERVAL_BITS = pitu_pkg::DEF_INTERVAL_BITS,
	parameter int unsigned WRAP_BITS     = pitu_pkg::DEF_WRAP_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  pitu_pkg::req_item_t item,
	output pitu_pkg::rsp_item_t result
);

	localparam int unsigned CW = INTERVAL_BITS + 1;
	localparam logic [31:0] MODE_RESET = 32'((64'd1 << INTERVAL_BITS) - 64'd1);

	logic [31:0]            mode_q, mode_d;
	logic                   status_q, status_d;
	logic [WRAP_BITS-1:0]   wrap_q, wrap_d;
	logic [CW-1:0]          remaining_q, remaining_d;
	logic [CW-1:0]          reload_q, reload_d;
	logic                   running_q, running_d;
	logic                   irq_q, irq_d;

	logic [CW-1:0]          elapsed_full;
	logic [63:0]            value_wide;
	logic [31:0]            value_word;
	logic [31:0]            rd;
	logic                   err;

	assign elapsed_full = reload_q - remaining_q;
	assign value_wide   = 64'({wrap_q, elapsed_full[INTERVAL_BITS-1:0]});
	assign value_word   = value_wide[31:0];

	always_comb begin
		mode_d      = mode_q;
		status_d    = status_q;
		wrap_d      = wrap_q;
		remaining_d = remaining_q;
		reload_d    = reload_q;
		running_d   = running_q;
		irq_d       = irq_q;
		rd          = '0;
		err         = 1'b0;
		case (item.req_type)
			pitu_pkg::REQ_TICK: begin
				if (running_q) begin
					// a remaining of zero or one wraps
					if (remaining_q[CW-1:1] == '0) begin
						remaining_d = reload_q;
						status_d    = 1'b1;
						wrap_d      = wrap_q + WRAP_BITS'(1);
						if (mode_q[pitu_pkg::IEN_BIT]) irq_d = 1'b1;
						if (!mode_q[pitu_pkg::EN_BIT]) running_d = 1'b0;
					end else begin
						remaining_d = remaining_q - CW'(1);
					end
				end
			end
			pitu_pkg::REQ_READ: begin
				case (item.reg_index)
					pitu_pkg::REG_MODE:   rd = mode_q;
					pitu_pkg::REG_STATUS: rd = {31'd0, status_q};
					pitu_pkg::REG_VALUE: begin
						rd       = value_word;
						wrap_d   = '0;
						status_d = 1'b0;
						irq_d    = 1'b0;
					end
					default: rd = value_word;
				endcase
			end
			pitu_pkg::REQ_WRITE: begin
				if (item.reg_index == pitu_pkg::REG_MODE) begin
					mode_d = item.write_data;
					if (item.write_data[pitu_pkg::EN_BIT]) begin
						reload_d    = {1'b0, item.write_data[INTERVAL_BITS-1:0]} + CW'(1);
						remaining_d = {1'b0, item.write_data[INTERVAL_BITS-1:0]} + CW'(1);
						running_d   = 1'b1;
					end
				end else begin
					err = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign result.read_data    = rd;
	assign result.irq_level    = irq_d;
	assign result.access_error = err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RESET;
			status_q    <= 1'b0;
			wrap_q      <= '0;
			remaining_q <= '0;
			reload_q    <= '0;
			running_q   <= 1'b0;
			irq_q       <= 1'b0;
		end else if (fire) begin
			mode_q      <= mode_d;
			status_q    <= status_d;
			wrap_q      <= wrap_d;
			remaining_q <= remaining_d;
			reload_q    <= reload_d;
			running_q   <= running_d;
			irq_q       <= irq_d;
		end
	end

endmodule

// ----- design/pitu_outq.sv -----
// Two-entry result queue (output register plus skid) for the periodic interval timer unit.
// Depends on pitu_pkg and periodic_interval_timer_unit_macros.svh.
`include "periodic_interval_timer_unit_macros.svh"

module pitu_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pitu_pkg::rsp_item_t push_item,
	output logic                room,
	output logic                valid,
	input  logic                stall,
	output pitu_pkg::rsp_item_t head
);

	logic [1:0]          count_q;
	pitu_pkg::rsp_item_t head_q;
	pitu_pkg::rsp_item_t skid_q;
	logic                pop;

	assign valid = (count_q != 2'd0);
	assign room  = (count_q != 2'd2);
	assign head  = head_q;
	assign pop   = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (count_q == 2'd2) begin
				head_q <= skid_q;
				if (push) skid_q <= push_item;
			end else if (push) begin
				head_q <= push_item;
			end
		end else if (push) begin
			if (count_q == 2'd0) head_q <= push_item;
			else skid_q <= push_item;
		end
	end

	`PITU_ASSERT(a_no_push_when_full, !(push && count_q == 2'd2), "item pushed into full queue")
	`PITU_ASSERT(a_count_range, count_q != 2'd3, "queue count out of range")
	`PITU_ASSERT_NEXT(a_push_shows, push && count_q == 2'd0, valid, "pushed item not presented")
	`PITU_ASSERT_NEXT(a_skid_drains, count_q == 2'd2 && pop && !push, count_q == 2'd1 && valid, "skid entry lost on pop")

endmodule

// ----- design/periodic_interval_timer_unit.sv -----
// Periodic interval timer unit, top level.
// Channels: req (req_valid/req_stall, struct req carrying req_type, reg_index,
// write_data) and rsp (rsp_valid/rsp_stall, struct rsp carrying read_data,
// irq_level, access_error). An item moves when valid is high and stall is low.
// Every request item gives exactly one response item, in order.
// A request accepted from req is registered in the input register; once the
// result queue has room, it is processed against the timer state and pushed
// into the result queue, which raises rsp_valid.
// Throughput: one item per cycle while rsp_stall stays low, set by the single
// input register feeding a two-entry result queue.
// When the receiver stalls, the queue fills (output register plus skid), then
// req_stall rises and the input register holds its item; no item is dropped.
// Reset (arst_n low) empties the pipeline, loads the mode word with the full
// interval mask and clears status, wrap count, counter, reload and interrupt.
// Depends on pitu_pkg, pitu_core and pitu_outq.
module periodic_interval_timer_unit #(
	parameter int unsigned INTERVAL_BITS = pitu_pkg::DEF_INTERVAL_BITS,
	parameter int unsigned WRAP_BITS     = pitu_pkg::DEF_WRAP_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pitu_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pitu_pkg::rsp_item_t rsp
);

	logic                valid_s1;
	pitu_pkg::req_item_t item_s1;
	logic                room;
	logic                advance;
	pitu_pkg::rsp_item_t result;

	assign advance   = valid_s1 && room;
	assign req_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) item_s1 <= req;
	end

	pitu_core #(
		.INTERVAL_BITS(INTERVAL_BITS),
		.WRAP_BITS(WRAP_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.item(item_s1),
		.result(result)
	);

	pitu_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(advance),
		.push_item(result),
		.room(room),
		.valid(rsp_valid),
		.stall(rsp_stall),
		.head(rsp)
	);

endmodule
